### sv/sh2d_pkg.sv
// Package: decode types, operation and kind codes, and the decode function.
`timescale 1ns / 1ps
`default_nettype none

package sh2d_pkg;

	typedef enum logic [5:0] {
		OP_UNKNOWN    = 6'd0,
		OP_MOVW_LD    = 6'd1,
		OP_MOVL_LD    = 6'd2,
		OP_MOV_RR     = 6'd3,
		OP_MOVL_PCREL = 6'd4,
		OP_BRA        = 6'd5,
		OP_JSR        = 6'd6,
		OP_NOP        = 6'd7,
		OP_MOVL_PUSH  = 6'd8,
		OP_RTS        = 6'd9,
		OP_MOVW_PCREL = 6'd10,
		OP_MOVL_POP   = 6'd11,
		OP_STSL_PR    = 6'd12,
		OP_LDSL_PR    = 6'd13,
		OP_MOV_IMM    = 6'd14,
		OP_ADD_IMM    = 6'd15,
		OP_MOVW_ST    = 6'd16,
		OP_MOVL_ST    = 6'd17,
		OP_TST        = 6'd18,
		OP_CMPEQ_IMM  = 6'd19,
		OP_CMPEQ_RR   = 6'd20,
		OP_BF         = 6'd21,
		OP_BT         = 6'd22,
		OP_BSR        = 6'd23,
		OP_JMP        = 6'd24,
		OP_MOVL_LDDSP = 6'd25,
		OP_MOVL_STDSP = 6'd26,
		OP_MOVW_STDSP = 6'd27,
		OP_MOVW_LDDSP = 6'd28,
		OP_MOVB_LD    = 6'd29,
		OP_MOVB_ST    = 6'd30,
		OP_ADD        = 6'd31,
		OP_SUB        = 6'd32,
		OP_SHLL       = 6'd33,
		OP_SHLR       = 6'd34,
		OP_SHLL2      = 6'd35,
		OP_SHLR2      = 6'd36,
		OP_CLRMAC     = 6'd37,
		OP_CLRT       = 6'd38,
		OP_SETT       = 6'd39
	} op_t;

	typedef enum logic [2:0] {
		MK_NONE = 3'd0,
		MK_RS8  = 3'd1,
		MK_RS16 = 3'd2,
		MK_RU32 = 3'd3,
		MK_WU8  = 3'd4,
		MK_WU16 = 3'd5,
		MK_WU32 = 3'd6
	} mem_kind_t;

	typedef enum logic [2:0] {
		FK_SEQ  = 3'd0,
		FK_BR   = 3'd1,
		FK_CBR  = 3'd2,
		FK_CALL = 3'd3,
		FK_JMP  = 3'd4,
		FK_RET  = 3'd5,
		FK_ILL  = 3'd6
	} flow_kind_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] rn;
		logic [3:0] rm;
		logic [11:0] disp;
		mem_kind_t  mem;
		flow_kind_t flow;
		logic       ds;
	} dec_t;

	localparam logic [1:0] INSN_BYTES = 2'd2;

	// Top-nibble groups
	localparam logic [3:0] HI_0 = 4'h0;
	localparam logic [3:0] HI_1 = 4'h1;
	localparam logic [3:0] HI_2 = 4'h2;
	localparam logic [3:0] HI_3 = 4'h3;
	localparam logic [3:0] HI_5 = 4'h5;
	localparam logic [3:0] HI_6 = 4'h6;
	localparam logic [3:0] HI_7 = 4'h7;
	localparam logic [3:0] HI_9 = 4'h9;
	localparam logic [3:0] HI_A = 4'hA;
	localparam logic [3:0] HI_B = 4'hB;
	localparam logic [3:0] HI_D = 4'hD;
	localparam logic [3:0] HI_E = 4'hE;

	// Low-nibble sub-ops
	localparam logic [3:0] LO_0 = 4'h0;
	localparam logic [3:0] LO_1 = 4'h1;
	localparam logic [3:0] LO_2 = 4'h2;
	localparam logic [3:0] LO_3 = 4'h3;
	localparam logic [3:0] LO_6 = 4'h6;
	localparam logic [3:0] LO_8 = 4'h8;
	localparam logic [3:0] LO_C = 4'hC;

	// Patterns under the Rn-don't-care mask and the top-byte mask, and whole-word matches
	localparam logic [15:0] MASK_RN   = 16'hF0FF;
	localparam logic [15:0] MASK_TOP8 = 16'hFF00;
	localparam logic [15:0] PAT_JSR   = 16'h400B;
	localparam logic [15:0] PAT_STSL  = 16'h4022;
	localparam logic [15:0] PAT_LDSL  = 16'h4026;
	localparam logic [15:0] PAT_JMP   = 16'h402B;
	localparam logic [15:0] PAT_SHLL  = 16'h4000;
	localparam logic [15:0] PAT_SHLR  = 16'h4001;
	localparam logic [15:0] PAT_SHLL2 = 16'h4008;
	localparam logic [15:0] PAT_SHLR2 = 16'h4009;
	localparam logic [15:0] PAT_CMPEQ = 16'h8800;
	localparam logic [15:0] PAT_BF    = 16'h8B00;
	localparam logic [15:0] PAT_BT    = 16'h8900;
	localparam logic [15:0] PAT_MOVWS = 16'h8100;
	localparam logic [15:0] PAT_MOVWL = 16'h8500;
	localparam logic [15:0] W_NOP     = 16'h0009;
	localparam logic [15:0] W_RTS     = 16'h000B;
	localparam logic [15:0] W_CLRMAC  = 16'h0028;
	localparam logic [15:0] W_CLRT    = 16'h0008;
	localparam logic [15:0] W_SETT    = 16'h0018;

	function automatic dec_t mk(op_t op, logic [3:0] rn, logic [3:0] rm, logic [11:0] disp,
			mem_kind_t mem, flow_kind_t flow, logic ds);
		dec_t d;
		d.op = op; d.rn = rn; d.rm = rm; d.disp = disp;
		d.mem = mem; d.flow = flow; d.ds = ds;
		return d;
	endfunction

	// First matching pattern wins.
	function automatic dec_t sh2d_decode(logic [15:0] w);
		logic [3:0]  hi;
		logic [3:0]  lo;
		logic [3:0]  n;
		logic [3:0]  m;
		logic [11:0] i8;
		logic [11:0] l4;
		logic [11:0] d12;
		logic [15:0] m4;
		logic [15:0] top8;
		dec_t        d;
		hi   = w[15:12];
		lo   = w[3:0];
		n    = w[11:8];
		m    = w[7:4];
		i8   = {4'd0, w[7:0]};
		l4   = {8'd0, w[3:0]};
		d12  = w[11:0];
		m4   = w & MASK_RN;
		top8 = w & MASK_TOP8;
		priority if (hi == HI_6 && lo == LO_1) d = mk(OP_MOVW_LD, n, m, '0, MK_RS16, FK_SEQ, 1'b0);
		else if (hi == HI_6 && lo == LO_2) d = mk(OP_MOVL_LD, n, m, '0, MK_RU32, FK_SEQ, 1'b0);
		else if (hi == HI_6 && lo == LO_3) d = mk(OP_MOV_RR, n, m, '0, MK_NONE, FK_SEQ, 1'b0);
		else if (hi == HI_D) d = mk(OP_MOVL_PCREL, n, '0, i8, MK_RU32, FK_SEQ, 1'b0);
		else if (hi == HI_A) d = mk(OP_BRA, '0, '0, d12, MK_NONE, FK_BR, 1'b1);
		else if (m4 == PAT_JSR) d = mk(OP_JSR, n, '0, '0, MK_NONE, FK_CALL, 1'b1);
		else if (w == W_NOP) d = mk(OP_NOP, '0, '0, '0, MK_NONE, FK_SEQ, 1'b0);
		else if (hi == HI_2 && lo == LO_6) d = mk(OP_MOVL_PUSH, n, m, '0, MK_WU32, FK_SEQ, 1'b0);
		else if (w == W_RTS) d = mk(OP_RTS, '0, '0, '0, MK_NONE, FK_RET, 1'b1);
		else if (hi == HI_9) d = mk(OP_MOVW_PCREL, n, '0, i8, MK_RS16, FK_SEQ, 1'b0);
		else if (hi == HI_6 && lo == LO_6) d = mk(OP_MOVL_POP, n, m, '0, MK_RU32, FK_SEQ, 1'b0);
		else if (m4 == PAT_STSL) d = mk(OP_STSL_PR, n, '0, '0, MK_WU32, FK_SEQ, 1'b0);
		// LDS.L takes its source register from bits 11..8
		else if (m4 == PAT_LDSL) d = mk(OP_LDSL_PR, '0, n, '0, MK_RU32, FK_SEQ, 1'b0);
		else if (hi == HI_E) d = mk(OP_MOV_IMM, n, '0, i8, MK_NONE, FK_SEQ, 1'b0);
		else if (hi == HI_7) d = mk(OP_ADD_IMM, n, '0, i8, MK_NONE, FK_SEQ, 1'b0);
		else if (hi == HI_2 && lo == LO_1) d = mk(OP_MOVW_ST, n, m, '0, MK_WU16, FK_SEQ, 1'b0);
		else if (hi == HI_2 && lo == LO_2) d = mk(OP_MOVL_ST, n, m, '0, MK_WU32, FK_SEQ, 1'b0);
		else if (hi == HI_2 && lo == LO_8) d = mk(OP_TST, n, m, '0, MK_NONE, FK_SEQ, 1'b0);
		else if (top8 == PAT_CMPEQ) d = mk(OP_CMPEQ_IMM, '0, '0, i8, MK_NONE, FK_SEQ, 1'b0);
		else if (hi == HI_3 && lo == LO_0) d = mk(OP_CMPEQ_RR, n, m, '0, MK_NONE, FK_SEQ, 1'b0);
		else if (top8 == PAT_BF) d = mk(OP_BF, '0, '0, i8, MK_NONE, FK_CBR, 1'b0);
		else if (top8 == PAT_BT) d = mk(OP_BT, '0, '0, i8, MK_NONE, FK_CBR, 1'b0);
		else if (hi == HI_B) d = mk(OP_BSR, '0, '0, d12, MK_NONE, FK_CALL, 1'b1);
		else if (m4 == PAT_JMP) d = mk(OP_JMP, n, '0, '0, MK_NONE, FK_JMP, 1'b1);
		else if (hi == HI_5) d = mk(OP_MOVL_LDDSP, n, m, l4, MK_RU32, FK_SEQ, 1'b0);
		else if (hi == HI_1) d = mk(OP_MOVL_STDSP, n, m, l4, MK_WU32, FK_SEQ, 1'b0);
		// base register of MOV.W R0,@(disp,Rn) sits in bits 7..4
		else if (top8 == PAT_MOVWS) d = mk(OP_MOVW_STDSP, m, '0, l4, MK_WU16, FK_SEQ, 1'b0);
		else if (top8 == PAT_MOVWL) d = mk(OP_MOVW_LDDSP, '0, m, l4, MK_RS16, FK_SEQ, 1'b0);
		else if (hi == HI_6 && lo == LO_0) d = mk(OP_MOVB_LD, n, m, '0, MK_RS8, FK_SEQ, 1'b0);
		else if (hi == HI_2 && lo == LO_0) d = mk(OP_MOVB_ST, n, m, '0, MK_WU8, FK_SEQ, 1'b0);
		else if (hi == HI_3 && lo == LO_C) d = mk(OP_ADD, n, m, '0, MK_NONE, FK_SEQ, 1'b0);
		else if (hi == HI_3 && lo == LO_8) d = mk(OP_SUB, n, m, '0, MK_NONE, FK_SEQ, 1'b0);
		else if (m4 == PAT_SHLL) d = mk(OP_SHLL, n, '0, '0, MK_NONE, FK_SEQ, 1'b0);
		else if (m4 == PAT_SHLR) d = mk(OP_SHLR, n, '0, '0, MK_NONE, FK_SEQ, 1'b0);
		else if (m4 == PAT_SHLL2) d = mk(OP_SHLL2, n, '0, '0, MK_NONE, FK_SEQ, 1'b0);
		else if (m4 == PAT_SHLR2) d = mk(OP_SHLR2, n, '0, '0, MK_NONE, FK_SEQ, 1'b0);
		else if (w == W_CLRMAC) d = mk(OP_CLRMAC, '0, '0, '0, MK_NONE, FK_SEQ, 1'b0);
		else if (w == W_CLRT) d = mk(OP_CLRT, '0, '0, '0, MK_NONE, FK_SEQ, 1'b0);
		else if (w == W_SETT) d = mk(OP_SETT, '0, '0, '0, MK_NONE, FK_SEQ, 1'b0);
		else d = mk(OP_UNKNOWN, '0, '0, '0, MK_NONE, FK_ILL, 1'b0);
		return d;
	endfunction

endpackage

`default_nettype wire

### sv/sh2_instruction_subset_decoder.sv
// Top level: two-stage registered decoder for a subset of 16-bit SH-2 instruction words.
`timescale 1ns / 1ps
`default_nettype none

// Channel | handshake            | payload
// --------+----------------------+-----------------------------------------------
// in      | in_valid / in_ready  | opcode, fetch_pc
// out     | out_valid / out_ready| op_number, reg_n, reg_m, displacement, mem_kind,
//         |                      | flow_kind, delay_slot, length_bytes, raw_word, pc_out
//
// One request per cycle sustained while out_ready stays high; an accepted request passes
// through the stage 1 and stage 2 registers before out_valid rises.
// Stage 1 registers the word and pc; the priority decode sits between stage 1 and stage 2.
// arst_n clears only the two stage valid bits; payload registers are not reset.
// A stall on out_ready holds stage 2, and stage 1 advances into it as soon as it frees,
// so in_ready drops only when both stages are full and the output is stalled.

module sh2_instruction_subset_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] opcode,
	input  wire logic [31:0] fetch_pc,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       op_number,
	output logic [3:0]       reg_n,
	output logic [3:0]       reg_m,
	output logic [11:0]      displacement,
	output logic [2:0]       mem_kind,
	output logic [2:0]       flow_kind,
	output logic             delay_slot,
	output logic [1:0]       length_bytes,
	output logic [15:0]      raw_word,
	output logic [31:0]      pc_out
);
	import sh2d_pkg::*;

	// stage 1: captured request
	logic        valid_s1;
	logic [15:0] word_s1;
	logic [31:0] pc_s1;

	// stage 2: decoded result waiting for the consumer
	logic        valid_s2;
	dec_t        dec_s2;
	logic [15:0] word_s2;
	logic [31:0] pc_s2;

	logic adv_s2;
	logic adv_s1;
	dec_t dec_comb;

	// stage 2 takes new data when empty or being drained this cycle
	assign adv_s2   = !valid_s2 || out_ready;
	// stage 1 frees when empty or moving into stage 2
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign dec_comb = sh2d_decode(word_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload: load on advance, hold otherwise
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			word_s1 <= opcode;
			pc_s1   <= fetch_pc;
		end
		if (adv_s2 && valid_s1) begin
			dec_s2  <= dec_comb;
			word_s2 <= word_s1;
			pc_s2   <= pc_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign op_number    = dec_s2.op;
	assign reg_n        = dec_s2.rn;
	assign reg_m        = dec_s2.rm;
	assign displacement = dec_s2.disp;
	assign mem_kind     = dec_s2.mem;
	assign flow_kind    = dec_s2.flow;
	assign delay_slot   = dec_s2.ds;
	assign length_bytes = INSN_BYTES;
	assign raw_word     = word_s2;
	assign pc_out       = pc_s2;

endmodule

`default_nettype wire
